@@ rtl/clm_pkg.sv @@
// shared constants for the crontab line matcher: character codes, parse phases, field codes
`timescale 1ns / 1ps

package clm_pkg;

    // characters that steer the parser
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // decimal radix for the number accumulator
    localparam logic [3:0] RADIX = 4'd10;
    // numbers saturate here
    localparam logic [7:0] NUM_MAX = 8'd255;

    // parse phases within one field
    localparam logic [2:0] PH_FIRST = 3'd0;
    localparam logic [2:0] PH_STAR  = 3'd1;
    localparam logic [2:0] PH_LIST  = 3'd2;
    localparam logic [2:0] PH_RANGE = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // field index codes: the five schedule fields, then the command and a broken line
    localparam logic [2:0] FIELD_MINUTE  = 3'd0;
    localparam logic [2:0] FIELD_HOUR    = 3'd1;
    localparam logic [2:0] FIELD_DAY     = 3'd2;
    localparam logic [2:0] FIELD_MONTH   = 3'd3;
    localparam logic [2:0] FIELD_WEEKDAY = 3'd4;
    localparam logic [2:0] FIELD_CMD     = 3'd5;
    localparam logic [2:0] FIELD_BROKEN  = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_MINUTE  = 3'd0;
    localparam logic [2:0] REG_HOUR    = 3'd1;
    localparam logic [2:0] REG_DAY     = 3'd2;
    localparam logic [2:0] REG_MONTH   = 3'd3;
    localparam logic [2:0] REG_WEEKDAY = 3'd4;

endpackage

@@ rtl/crontab_line_matcher_unit.sv @@
// top level of the crontab line matcher: byte register, parser state and result register
`timescale 1ns / 1ps

// Streaming matcher for crontab schedule lines. Bytes enter one a beat on the input
// channel; a line closes on a byte flagged by i_line_end, or once LINE_BUFFER-1 bytes
// have been taken. The first five blank-separated fields (minute, hour, day, month,
// weekday) are parsed on the fly and compared with the time held in the configuration
// registers; one result beat follows each closed line with the match flag, the
// well-formed flag, the position of the command and the line length. The block takes
// one byte every cycle unless a waiting result is stalled while the input register is
// full. A closing byte passes through the input byte register and then the parser
// update into the result register. A waiting result holds back the parser only, so
// one more byte is still taken into the input register. Configuration must be
// written only while no line byte is in flight; the block does not enforce this.

module crontab_line_matcher_unit #(
    parameter int LINE_BUFFER = 132
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_ch,
    input  logic       i_line_end,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_line_matched,
    output logic       o_well_formed,
    output logic [7:0] o_command_start,
    output logic [7:0] o_line_length,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [5:0] i_cfg_data
);

    // line closes once this many bytes are in
    localparam logic [8:0] LIMIT = 9'(LINE_BUFFER - 1);

    // configuration registers
    logic [5:0] r_now_minute;
    logic [4:0] r_now_hour;
    logic [4:0] r_now_day;
    logic [3:0] r_now_month;
    logic [2:0] r_now_weekday;

    // input byte register
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_last;

    // parser state
    logic [7:0] r_byte_count, n_byte_count;
    logic [2:0] r_field, n_field;
    logic [2:0] r_phase, n_phase;
    logic       r_token_empty, n_token_empty;
    logic       r_in_gap, n_in_gap;
    logic [7:0] r_accum, n_accum;
    logic       r_field_hit, n_field_hit;
    logic       r_low_ok, n_low_ok;
    logic       r_all_hit, n_all_hit;
    logic [7:0] r_cmd_pos, n_cmd_pos;

    // result register
    logic       r_out_valid;
    logic       r_matched;
    logic       r_wf;
    logic [7:0] r_cmd_out;
    logic [7:0] r_len_out;

    // pipeline control
    logic advance;
    logic fire;

    // per-byte decode
    logic       is_digit;
    logic       is_sep;
    logic [7:0] right;
    logic [11:0] acc_wide;
    logic [7:0] acc_next;
    logic       fld_result;
    logic [8:0] length;
    logic       emit;
    logic       wf;

    // field byte outcome
    logic [2:0] f_phase;
    logic       f_token_empty;
    logic [7:0] f_accum;
    logic       f_field_hit;
    logic       f_low_ok;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    // configuration writes; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now_minute  <= 6'd0;
            r_now_hour    <= 5'd0;
            r_now_day     <= 5'd1;
            r_now_month   <= 4'd1;
            r_now_weekday <= 3'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                clm_pkg::REG_MINUTE:  r_now_minute  <= i_cfg_data;
                clm_pkg::REG_HOUR:    r_now_hour    <= i_cfg_data[4:0];
                clm_pkg::REG_DAY:     r_now_day     <= i_cfg_data[4:0];
                clm_pkg::REG_MONTH:   r_now_month   <= i_cfg_data[3:0];
                clm_pkg::REG_WEEKDAY: r_now_weekday <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // input byte register, refilled in the same cycle it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_ch   <= i_ch;
            r_last <= i_line_end;
        end
    end

    // time value the current field is compared with
    always_comb begin
        case (r_field)
            clm_pkg::FIELD_MINUTE:  right = {2'b00, r_now_minute};
            clm_pkg::FIELD_HOUR:    right = {3'b000, r_now_hour};
            clm_pkg::FIELD_DAY:     right = {3'b000, r_now_day};
            clm_pkg::FIELD_MONTH:   right = {4'b0000, r_now_month};
            clm_pkg::FIELD_WEEKDAY: right = {5'b00000, r_now_weekday};
            default:                right = 8'd0;
        endcase
    end

    assign is_digit = (r_ch >= clm_pkg::CH_ZERO) && (r_ch <= clm_pkg::CH_NINE);
    assign is_sep   = (r_ch == clm_pkg::CH_SPACE) || (r_ch == clm_pkg::CH_TAB);

    // times ten plus digit, saturating
    assign acc_wide = 12'(r_accum) * 12'(clm_pkg::RADIX) + 12'(r_ch - clm_pkg::CH_ZERO);
    assign acc_next = (acc_wide > 12'(clm_pkg::NUM_MAX)) ? clm_pkg::NUM_MAX : acc_wide[7:0];

    // verdict of a field closed by a blank
    always_comb begin
        case (r_phase)
            clm_pkg::PH_FIRST: fld_result = (r_accum == right);
            clm_pkg::PH_STAR:  fld_result = 1'b1;
            clm_pkg::PH_LIST:  fld_result = r_field_hit || (r_accum == right);
            clm_pkg::PH_RANGE: fld_result = r_low_ok && (right <= r_accum);
            default:           fld_result = r_field_hit;
        endcase
    end

    // one non-blank byte inside a field
    always_comb begin
        f_phase       = r_phase;
        f_token_empty = r_token_empty;
        f_accum       = r_accum;
        f_field_hit   = r_field_hit;
        f_low_ok      = r_low_ok;
        case (r_phase)
            clm_pkg::PH_FIRST: begin
                if (is_digit) begin
                    f_accum = acc_next;
                end else if (r_ch == clm_pkg::CH_STAR && r_token_empty) begin
                    f_phase = clm_pkg::PH_STAR;
                end else if (r_ch == clm_pkg::CH_COMMA) begin
                    f_field_hit = (r_accum == right);
                    f_accum     = 8'd0;
                    f_phase     = clm_pkg::PH_LIST;
                end else if (r_ch == clm_pkg::CH_DASH) begin
                    f_low_ok = (right >= r_accum);
                    f_accum  = 8'd0;
                    f_phase  = clm_pkg::PH_RANGE;
                end else begin
                    // unknown character kills the field
                    f_field_hit = 1'b0;
                    f_phase     = clm_pkg::PH_DONE;
                end
                f_token_empty = 1'b0;
            end
            clm_pkg::PH_STAR: begin
                // anything after a lone star spoils it
                f_field_hit = 1'b0;
                f_phase     = clm_pkg::PH_DONE;
            end
            clm_pkg::PH_LIST: begin
                if (is_digit) begin
                    f_accum = acc_next;
                end else begin
                    if (r_accum == right) begin
                        f_field_hit = 1'b1;
                    end
                    f_accum = 8'd0;
                    if (r_ch != clm_pkg::CH_COMMA) begin
                        f_phase = clm_pkg::PH_DONE;
                    end
                end
            end
            clm_pkg::PH_RANGE: begin
                if (is_digit) begin
                    f_accum = acc_next;
                end else begin
                    f_field_hit = r_low_ok && (right <= r_accum);
                    f_phase     = clm_pkg::PH_DONE;
                end
            end
            default: ;
        endcase
    end

    // line-level next state
    always_comb begin
        n_field       = r_field;
        n_phase       = r_phase;
        n_token_empty = r_token_empty;
        n_in_gap      = r_in_gap;
        n_accum       = r_accum;
        n_field_hit   = r_field_hit;
        n_low_ok      = r_low_ok;
        n_all_hit     = r_all_hit;
        n_cmd_pos     = r_cmd_pos;

        if (r_field < clm_pkg::FIELD_CMD) begin
            if (r_ch == clm_pkg::CH_NUL) begin
                n_field = clm_pkg::FIELD_BROKEN;
            end else if (r_in_gap && is_sep) begin
                // still in the blank run
            end else if (!r_in_gap && is_sep) begin
                // blank closes the field
                if (!fld_result) begin
                    n_all_hit = 1'b0;
                end
                n_field       = r_field + 3'd1;
                n_in_gap      = 1'b1;
                n_phase       = clm_pkg::PH_FIRST;
                n_token_empty = 1'b1;
                n_accum       = 8'd0;
                n_field_hit   = 1'b0;
                n_low_ok      = 1'b0;
            end else begin
                n_in_gap      = 1'b0;
                n_phase       = f_phase;
                n_token_empty = f_token_empty;
                n_accum       = f_accum;
                n_field_hit   = f_field_hit;
                n_low_ok      = f_low_ok;
            end
        end else if (r_field == clm_pkg::FIELD_CMD && r_in_gap && !is_sep) begin
            // first command byte
            n_in_gap  = 1'b0;
            n_cmd_pos = r_byte_count;
        end

        length       = {1'b0, r_byte_count} + 9'd1;
        n_byte_count = length[7:0];
        emit         = r_last || (length >= LIMIT);
        wf           = (n_field == clm_pkg::FIELD_CMD);
        if (wf && n_in_gap) begin
            // empty command sits at the line end
            n_cmd_pos = length[7:0];
        end
    end

    // parser state, back to line reset after each closed line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && emit)) begin
            r_byte_count  <= 8'd0;
            r_field       <= clm_pkg::FIELD_MINUTE;
            r_phase       <= clm_pkg::PH_FIRST;
            r_token_empty <= 1'b1;
            r_in_gap      <= 1'b0;
            r_accum       <= 8'd0;
            r_field_hit   <= 1'b0;
            r_low_ok      <= 1'b0;
            r_all_hit     <= 1'b1;
            r_cmd_pos     <= 8'd0;
        end else if (fire) begin
            r_byte_count  <= n_byte_count;
            r_field       <= n_field;
            r_phase       <= n_phase;
            r_token_empty <= n_token_empty;
            r_in_gap      <= n_in_gap;
            r_accum       <= n_accum;
            r_field_hit   <= n_field_hit;
            r_low_ok      <= n_low_ok;
            r_all_hit     <= n_all_hit;
            r_cmd_pos     <= n_cmd_pos;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_matched <= wf && n_all_hit;
            r_wf      <= wf;
            r_cmd_out <= wf ? n_cmd_pos : 8'd0;
            r_len_out <= length[7:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_matched  = r_matched;
    assign o_well_formed   = r_wf;
    assign o_command_start = r_cmd_out;
    assign o_line_length   = r_len_out;

    // a malformed line never reports a match or a command
    a_malformed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_well_formed |-> !o_line_matched && (o_command_start == 8'd0))
        else $error("malformed line reported match or command position");

    // command can never start past the line end
    a_cmd_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_well_formed |-> o_command_start <= o_line_length)
        else $error("command start beyond line length");

    // the open line never reaches the length limit
    a_count_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_byte_count} < LIMIT)
        else $error("byte count reached the length limit");

    // a byte is held back only when the byte register is full and blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // a closing byte lands in the result register on the next edge
    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && emit |=> o_out_valid && (o_line_length == $past(length[7:0])))
        else $error("closed line did not produce its result");

endmodule

@@ tb/sv/clm_line_checker_pkg.sv @@
// scoreboard for the crontab line matcher: line parser prediction and result comparison
`timescale 1ns / 1ps

package clm_line_checker_pkg;

    import clm_pkg::*;

    localparam int LINE_BUFFER  = 132;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic       matched;
        logic       formed;
        logic [7:0] cmd_start;
        logic [7:0] length;
    } line_verdict_t;

    class line_checker;
        // time registers as the block should hold them
        logic [5:0] now_minute;
        logic [4:0] now_hour;
        logic [4:0] now_day;
        logic [3:0] now_month;
        logic [2:0] now_weekday;

        // parser state of the line in progress
        logic [7:0] byte_count;
        logic [2:0] field_index;
        logic [2:0] phase;
        logic       token_empty;
        logic       in_gap;
        logic [7:0] accum;
        logic       field_hit;
        logic       low_ok;
        logic       all_hit;
        logic [7:0] cmd_position;

        line_verdict_t predicted_q[$];
        int            mismatches;

        function new();
            now_minute  = '0;
            now_hour    = '0;
            now_day     = 5'd1;
            now_month   = 4'd1;
            now_weekday = '0;
            mismatches  = 0;
            clear_line();
        endfunction

        function void clear_field();
            phase       = PH_FIRST;
            token_empty = 1'b1;
            accum       = '0;
            field_hit   = 1'b0;
            low_ok      = 1'b0;
        endfunction

        function void clear_line();
            byte_count   = '0;
            field_index  = FIELD_MINUTE;
            in_gap       = 1'b0;
            all_hit      = 1'b1;
            cmd_position = '0;
            clear_field();
        endfunction

        function void set_register(logic [2:0] index, logic [5:0] data);
            case (index)
                REG_MINUTE:  now_minute  = data;
                REG_HOUR:    now_hour    = data[4:0];
                REG_DAY:     now_day     = data[4:0];
                REG_MONTH:   now_month   = data[3:0];
                REG_WEEKDAY: now_weekday = data[2:0];
                default: ;
            endcase
        endfunction

        // time value that a schedule field is compared with
        function int now_of(int field);
            case (field)
                FIELD_MINUTE:  return now_minute;
                FIELD_HOUR:    return now_hour;
                FIELD_DAY:     return now_day;
                FIELD_MONTH:   return now_month;
                FIELD_WEEKDAY: return now_weekday;
                default:       return 0;
            endcase
        endfunction

        function void add_digit(logic [7:0] c);
            int v;
            v = int'(accum) * int'(RADIX) + int'(c - CH_ZERO);
            accum = (v > int'(NUM_MAX)) ? NUM_MAX : 8'(v);
        endfunction

        function logic field_result(int right);
            case (phase)
                PH_FIRST: return int'(accum) == right;
                PH_STAR:  return 1'b1;
                PH_LIST:  return field_hit || int'(accum) == right;
                PH_RANGE: return low_ok && right <= int'(accum);
                default:  return field_hit;
            endcase
        endfunction

        function void field_byte(logic [7:0] c, int right);
            logic digit;
            digit = c >= CH_ZERO && c <= CH_NINE;
            case (phase)
                PH_FIRST: begin
                    if (digit) begin
                        add_digit(c);
                    end else if (c == CH_STAR && token_empty) begin
                        phase = PH_STAR;
                    end else if (c == CH_COMMA) begin
                        field_hit = int'(accum) == right;
                        accum     = '0;
                        phase     = PH_LIST;
                    end else if (c == CH_DASH) begin
                        low_ok = right >= int'(accum);
                        accum  = '0;
                        phase  = PH_RANGE;
                    end else begin
                        field_hit = 1'b0;
                        phase     = PH_DONE;
                    end
                    token_empty = 1'b0;
                end
                PH_STAR: begin
                    field_hit = 1'b0;
                    phase     = PH_DONE;
                end
                PH_LIST: begin
                    if (digit) begin
                        add_digit(c);
                    end else begin
                        if (int'(accum) == right) field_hit = 1'b1;
                        accum = '0;
                        if (c != CH_COMMA) phase = PH_DONE;
                    end
                end
                PH_RANGE: begin
                    if (digit) begin
                        add_digit(c);
                    end else begin
                        field_hit = low_ok && right <= int'(accum);
                        phase     = PH_DONE;
                    end
                end
                default: ;
            endcase
        endfunction

        // one accepted byte; a closed line queues its verdict
        function void note_byte(logic [7:0] c, logic last);
            logic          sep;
            int            right;
            int            pos;
            int            length;
            line_verdict_t v;
            sep = c == CH_SPACE || c == CH_TAB;
            pos = byte_count;
            if (field_index < FIELD_CMD) begin
                right = now_of(field_index);
                if (c == CH_NUL) begin
                    field_index = FIELD_BROKEN;
                end else if (in_gap) begin
                    if (!sep) begin
                        in_gap = 1'b0;
                        field_byte(c, right);
                    end
                end else if (sep) begin
                    if (!field_result(right)) all_hit = 1'b0;
                    field_index = field_index + 3'd1;
                    in_gap      = 1'b1;
                    clear_field();
                end else begin
                    field_byte(c, right);
                end
            end else if (field_index == FIELD_CMD && in_gap && !sep) begin
                in_gap       = 1'b0;
                cmd_position = 8'(pos);
            end
            length     = pos + 1;
            byte_count = 8'(length);
            if (!last && length < LINE_BUFFER - 1) return;
            v.formed = field_index == FIELD_CMD;
            if (v.formed && in_gap) cmd_position = 8'(length);
            v.matched   = v.formed && all_hit;
            v.cmd_start = v.formed ? cmd_position : 8'd0;
            v.length    = 8'(length);
            predicted_q.push_back(v);
            clear_line();
        endfunction

        function void check_line(line_verdict_t got);
            line_verdict_t want;
            if (predicted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result beat: matched=%0b formed=%0b cmd=%0d len=%0d",
                             got.matched, got.formed, got.cmd_start, got.length);
                return;
            end
            want = predicted_q.pop_front();
            if (got.matched !== want.matched || got.formed !== want.formed ||
                got.cmd_start !== want.cmd_start || got.length !== want.length) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"line result mismatch: expected matched=%0b formed=%0b cmd=%0d",
                              " len=%0d, got matched=%0b formed=%0b cmd=%0d len=%0d"},
                             want.matched, want.formed, want.cmd_start, want.length,
                             got.matched, got.formed, got.cmd_start, got.length);
            end
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction
    endclass

endpackage

@@ tb/sv/tb.sv @@
// testbench top for the crontab line matcher: byte and config drivers, result monitor
`timescale 1ns / 1ps

module tb;

    import clm_pkg::*;
    import clm_line_checker_pkg::*;

    localparam int     ITEM_TARGET   = 850;
    localparam int     PHASE_ITEMS   = 110;
    localparam int     HOLD_STEP     = 3;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     RESET_CYCLES  = 12;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     TAIL_CYCLES   = 10;
    localparam longint TIMEOUT_NS    = 2_000_000;
    // index with no register behind it, a write there must change nothing
    localparam logic [2:0] REG_NONE = 3'd7;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_ch;
    logic       i_line_end;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_line_matched;
    logic       o_well_formed;
    logic [7:0] o_command_start;
    logic [7:0] o_line_length;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [5:0] i_cfg_data;

    line_checker sb;
    logic [7:0]  line_q[$];
    int          items_sent = 0;
    int          out_wait = 0;
    bit          sender_idle = 1'b1;
    bit          receiver_idle = 1'b1;
    bit          hold_go = 1'b0;
    bit          long_hold = 1'b0;

    crontab_line_matcher_unit #(
        .LINE_BUFFER(LINE_BUFFER)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_ch           (i_ch),
        .i_line_end     (i_line_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_line_matched (o_line_matched),
        .o_well_formed  (o_well_formed),
        .o_command_start(o_command_start),
        .o_line_length  (o_line_length),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // line builders: every builder but stray_char appends bytes to line_q
    // ---------------------------------------------------------------------

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endfunction

    function automatic void push_sep();
        line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    // numbers cluster on the current time so that fields hit often;
    // big ones exercise saturation, a leading zero now and then
    function automatic void push_number(int now);
        int    v;
        string s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = now;
            5, 6:          v = $urandom_range(0, now + 3);
            7:             v = $urandom_range(0, 99);
            8:             v = $urandom_range(200, 99999);
            default:       v = 0;
        endcase
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 7) == 0) s = {"0", s};
        push_text(s);
    endfunction

    // any byte the field parser does not treat as a digit, star, comma, dash or blank
    function automatic logic [7:0] stray_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_STAR || c == CH_COMMA ||
               c == CH_DASH || c == CH_SPACE || c == CH_TAB);
        return c;
    endfunction

    function automatic void push_field(int now);
        case ($urandom_range(0, 9))
            0, 1, 2: line_q.push_back(CH_STAR);
            3, 4:    push_number(now);
            5: begin
                // comma list, sometimes opening with an empty element
                if ($urandom_range(0, 3) == 0) line_q.push_back(CH_COMMA);
                push_number(now);
                repeat ($urandom_range(1, 3)) begin
                    line_q.push_back(CH_COMMA);
                    push_number(now);
                end
            end
            6: begin
                // low-high range, sometimes with the high number missing
                push_number(now);
                line_q.push_back(CH_DASH);
                if ($urandom_range(0, 5) != 0) push_number(now);
            end
            7: begin
                // star that is not alone in its field
                line_q.push_back(CH_STAR);
                case ($urandom_range(0, 2))
                    0:       line_q.push_back(CH_COMMA);
                    1:       line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    default: line_q.push_back(stray_char());
                endcase
            end
            8: begin
                // unknown character after the first number
                push_number(now);
                line_q.push_back(stray_char());
                if ($urandom_range(0, 1)) push_number(now);
            end
            default: begin
                // list or range followed by a tail that is skipped
                push_number(now);
                line_q.push_back($urandom_range(0, 1) ? CH_COMMA : CH_DASH);
                push_number(now);
                line_q.push_back(stray_char());
                push_number(now);
            end
        endcase
    endfunction

    // builds one line; returns whether its last byte carries the end marker
    function automatic bit build_line();
        int kind;
        int first;
        int cut;
        line_q.delete();
        kind = $urandom_range(0, 29);
        // pure noise
        if (kind == 27 || kind == 28) begin
            repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
            return 1'b1;
        end
        // leading blank: empty first field
        first = 0;
        if ($urandom_range(0, 9) == 0) begin
            push_sep();
            first = 1;
        end
        for (int f = first; f < 5; f++) begin
            push_field(sb.now_of(f));
            repeat ($urandom_range(1, 3)) push_sep();
        end
        // command, empty at times so the line ends in the gap
        repeat ($urandom_range(0, 10))
            line_q.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(8'h61, 8'h7A)));
        if (kind >= 22 && kind <= 24) begin
            // short line, ends before the schedule is complete or mid-command
            cut = $urandom_range(1, line_q.size() - 1);
            while (line_q.size() > cut) void'(line_q.pop_back());
        end else if (kind == 25 || kind == 26) begin
            line_q[$urandom_range(0, line_q.size() - 1)] = CH_NUL;
        end else if (kind == 29) begin
            // runs into the length limit, with or without the end marker on the last byte
            while (line_q.size() < LINE_BUFFER - 1) line_q.push_back(8'($urandom_range(0, 255)));
            return 1'b1 & $urandom_range(0, 1);
        end
        while (line_q.size() > LINE_BUFFER - 1) void'(line_q.pop_back());
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ---------------------------------------------------------------------

    // one byte beat; valid stays up when the next byte follows with no gap
    task automatic send_byte(input logic [7:0] ch, input logic last);
        int gap;
        gap = sender_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= ch;
        i_line_end <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(ch, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line(input bit close);
        for (int i = 0; i < line_q.size(); i++)
            send_byte(line_q[i], close && i == line_q.size() - 1);
    endtask

    // one register beat; valid stays up so back-to-back writes need no gap
    task automatic write_register(input logic [2:0] index, input logic [5:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(index, data);
        @(negedge i_clk);
    endtask

    // sender pause: every line closed and every result back, then a quiet settling wait
    task automatic wait_idle();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // current time for one phase: lowest values, highest values, all ones, then random
    task automatic set_time(input int step);
        logic [5:0] mi, hr, dy, mo, wd;
        case (step)
            0: begin
                // day and month below their range are compared as they are
                mi = 6'd0; hr = 6'd0; dy = 6'd0; mo = 6'd0; wd = 6'd0;
            end
            1: begin
                mi = 6'd59; hr = 6'd23; dy = 6'd31; mo = 6'd12; wd = 6'd6;
            end
            2: begin
                mi = 6'h3F; hr = 6'h3F; dy = 6'h3F; mo = 6'h3F; wd = 6'h3F;
            end
            default: begin
                mi = 6'($urandom_range(0, 59));
                hr = 6'($urandom_range(0, 23));
                dy = 6'($urandom_range(1, 31));
                mo = 6'($urandom_range(1, 12));
                wd = 6'($urandom_range(0, 6));
            end
        endcase
        write_register(REG_MINUTE, mi);
        write_register(REG_HOUR, hr);
        write_register(REG_DAY, dy);
        write_register(REG_MONTH, mo);
        write_register(REG_WEEKDAY, wd);
        if (step == 4) write_register(REG_NONE, 6'($urandom_range(0, 63)));
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------

    // result monitor: a beat moves at a rising edge with valid high and stall low
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_line({o_line_matched, o_well_formed, o_command_start, o_line_length});
            out_wait = receiver_idle ? $urandom_range(0, 7) : 0;
        end
    end

    // receiver stall, drawn per result beat, overridden by the long hold-off
    initial begin : receiver
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_stall <= 1'b1;
            end else if (out_wait > 0) begin
                i_out_stall <= 1'b1;
                out_wait--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // long hold-off, counted here so the sender keeps offering bytes meanwhile
    initial begin : hold_off
        wait (hold_go);
        @(posedge i_clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------

    initial begin : stimulus
        int    step;
        int    phase_end;
        string directed_text[2];
        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_ch        = '0;
        i_line_end  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_MINUTE;
        i_cfg_data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed lines against the reset time: a plain match on the reset values,
        // an all-star schedule with an empty command, a lone top byte, a lone nul
        directed_text[0] = "0 0 1 1 0 x";
        directed_text[1] = "* * * * *\t";
        foreach (directed_text[i]) begin
            line_q.delete();
            push_text(directed_text[i]);
            send_line(1'b1);
        end
        line_q.delete();
        line_q.push_back(8'hFF);
        send_line(1'b1);
        line_q.delete();
        line_q.push_back(CH_NUL);
        send_line(1'b1);

        // random phases, each under its own time setting
        step = 0;
        while (items_sent < ITEM_TARGET) begin
            i_in_valid <= 1'b0;
            wait_idle();
            set_time(step);
            // every fourth phase runs without gaps on either side
            receiver_idle = step % 4 != 2;
            sender_idle   = step % 4 != 2 && step != HOLD_STEP;
            if (step == HOLD_STEP) hold_go = 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < ITEM_TARGET)
                send_line(build_line());
            step++;
        end

        i_in_valid <= 1'b0;
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/clm_pkg.sv
rtl/crontab_line_matcher_unit.sv
tb/sv/clm_line_checker_pkg.sv
tb/sv/tb.sv
